>>> hw/rtl/twsb_pkg.sv
// ----------------------------------------------------------------------------
// twsb_pkg
// Shared types and codes for the time-window segment buffer.
// ----------------------------------------------------------------------------
package twsb_pkg;

    typedef enum logic [1:0] {
        FUNC_APPEND   = 2'd0,
        FUNC_SNAPSHOT = 2'd1,
        FUNC_CLEAR    = 2'd2,
        FUNC_TRIM     = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_ORDER   = 3'd2,
        ST_FULL    = 3'd3,
        ST_NONE    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        EX_IDLE,
        EX_EVICT,
        EX_FIND,
        EX_EMIT,
        EX_RESULT
    } exec_state_t;

    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned COUNT_W  = 6;

endpackage

>>> hw/rtl/twsb_ram.sv
// ----------------------------------------------------------------------------
// twsb_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module twsb_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hw/rtl/twsb_front.sv
// ----------------------------------------------------------------------------
// twsb_front
// Accepts command items and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module twsb_front #(
    parameter int unsigned CMD_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [CMD_W-1:0] in_cmd,
    output logic             q_valid,
    input  logic             q_ready,
    output logic [CMD_W-1:0] q_cmd
);

    logic [CMD_W-1:0] slot_reg [2];
    logic             rd_ptr_reg, rd_ptr_next;
    logic             wr_ptr_reg, wr_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // advance pointers and occupancy
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ pop;
        wr_ptr_next = wr_ptr_reg ^ push;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // hold payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

>>> hw/rtl/twsb_back.sv
// ----------------------------------------------------------------------------
// twsb_back
// Executes commands against the segment ring and emits result items.
// ----------------------------------------------------------------------------
module twsb_back #(
    parameter int unsigned DEPTH       = 32,
    parameter int unsigned TIME_BITS   = 48,
    parameter int unsigned HANDLE_BITS = 32,
    parameter int unsigned CMD_W       = 8,
    parameter int unsigned RES_W       = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [TIME_BITS-1:0]   window_length,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  logic [CMD_W-1:0]       q_cmd,
    output logic                   res_valid,
    input  logic                   res_ready,
    output logic [RES_W-1:0]       res_data
);
    import twsb_pkg::*;

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned TW = TIME_BITS;
    localparam int unsigned HW = HANDLE_BITS;

    // command fields
    logic [FUNC_W-1:0] c_func;
    logic [TW-1:0]     c_s, c_e, c_q;
    logic [HW-1:0]     c_h;
    assign {c_q, c_h, c_e, c_s, c_func} = q_cmd;

    exec_state_t       state_reg, state_next;
    logic [IW-1:0]     head_reg, head_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [TW-1:0]     newest_s_reg, newest_s_next;
    logic [TW-1:0]     newest_e_reg, newest_e_next;
    logic [TW-1:0]     oldest_s_reg, oldest_s_next;
    logic [FUNC_W-1:0] func_reg, func_next;
    logic [TW-1:0]     wend_reg, wend_next;
    logic signed [TW:0] req_reg, req_next;
    logic signed [TW:0] cutoff_reg, cutoff_next;
    logic [TW-1:0]     act_reg, act_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic              rd_wait_reg, rd_wait_next;
    logic              emitted_reg, emitted_next;
    logic [STATUS_W-1:0] st_reg, st_next;

    // result register
    logic              ov_reg, ov_next;
    logic [STATUS_W-1:0] o_status_reg, o_status_next;
    logic              o_iv_reg, o_iv_next, o_last_reg, o_last_next;
    logic [HW-1:0]     o_h_reg, o_h_next;
    logic [TW-1:0]     o_s_reg, o_s_next, o_e_reg, o_e_next;
    logic [TW-1:0]     o_wend_reg, o_wend_next, o_act_reg, o_act_next;
    logic signed [TW:0] o_req_reg, o_req_next;
    logic [COUNT_W-1:0] o_cnt_reg, o_cnt_next;
    logic [TW-1:0]     o_old_reg, o_old_next, o_new_reg, o_new_next;

    // memories
    logic              wr_en;
    logic [IW-1:0]     wr_addr, rd_addr, rd_nx_addr;
    logic [TW-1:0]     rd_s, rd_e, rd_nx_s;
    logic [HW-1:0]     rd_h;
    logic              nx_last;

    twsb_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_start (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(c_s),
        .rd_addr(rd_addr), .rd_data(rd_s));
    twsb_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_start_nx (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(c_s),
        .rd_addr(rd_nx_addr), .rd_data(rd_nx_s));
    twsb_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_end (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(c_e),
        .rd_addr(rd_addr), .rd_data(rd_e));
    twsb_ram #(.WIDTH(HW), .DEPTH(DEPTH)) u_handle (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(c_h),
        .rd_addr(rd_addr), .rd_data(rd_h));

    function automatic logic [IW-1:0] ring(input logic [IW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = {{(CW+1-IW){1'b0}}, base} + {1'b0, off};
        if (sum >= (CW+1)'(DEPTH))
        begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    assign wr_addr    = ring(head_reg, cnt_reg);
    assign rd_addr    = ring(head_reg, idx_reg);
    assign rd_nx_addr = ring(head_reg, idx_reg + CW'(1));
    assign res_valid = ov_reg;
    assign res_data = {o_new_reg, o_old_reg, o_cnt_reg, o_last_reg, o_act_reg,
                       o_req_reg, o_wend_reg, o_e_reg, o_s_reg, o_h_reg,
                       o_iv_reg, o_status_reg};

    // entry idx_reg is the last selected one when no later entry starts before wend
    assign nx_last = (idx_reg + CW'(1) >= cnt_reg) || (rd_nx_s >= wend_reg);

    logic signed [TW:0] rd_s_x, rd_e_x;
    assign rd_s_x = $signed({1'b0, rd_s});
    assign rd_e_x = $signed({1'b0, rd_e});

    // sequencer: next state and outputs
    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        cnt_next      = cnt_reg;
        newest_s_next = newest_s_reg;
        newest_e_next = newest_e_reg;
        oldest_s_next = oldest_s_reg;
        func_next     = func_reg;
        wend_next     = wend_reg;
        req_next      = req_reg;
        cutoff_next   = cutoff_reg;
        act_next      = act_reg;
        idx_next      = idx_reg;
        rd_wait_next  = rd_wait_reg;
        emitted_next  = emitted_reg;
        st_next       = st_reg;
        q_ready       = 1'b0;
        wr_en         = 1'b0;
        ov_next       = ov_reg && !res_ready;
        o_status_next = o_status_reg;
        o_iv_next     = o_iv_reg;
        o_last_next   = o_last_reg;
        o_h_next      = o_h_reg;
        o_s_next      = o_s_reg;
        o_e_next      = o_e_reg;
        o_wend_next   = o_wend_reg;
        o_req_next    = o_req_reg;
        o_act_next    = o_act_reg;
        o_cnt_next    = o_cnt_reg;
        o_old_next    = o_old_reg;
        o_new_next    = o_new_reg;

        unique case (state_reg)
            EX_IDLE:
            begin
                q_ready   = 1'b1;
                func_next = c_func;
                st_next   = ST_OK;
                idx_next  = '0;
                rd_wait_next = 1'b1;
                emitted_next = 1'b0;
                cutoff_next  = $signed({1'b0, newest_e_reg})
                               - $signed({1'b0, window_length});
                if (q_valid)
                begin
                    unique case (func_t'(c_func))
                        FUNC_APPEND:
                        begin
                            if (c_e <= c_s)
                            begin
                                st_next = ST_INVALID;
                                state_next = EX_RESULT;
                            end
                            else if (cnt_reg != '0 && c_s < newest_s_reg)
                            begin
                                st_next = ST_ORDER;
                                state_next = EX_RESULT;
                            end
                            else if (cnt_reg == CW'(DEPTH))
                            begin
                                st_next = ST_FULL;
                                state_next = EX_RESULT;
                            end
                            else
                            begin
                                wr_en = 1'b1;
                                if (cnt_reg == '0)
                                begin
                                    oldest_s_next = c_s;
                                end
                                cnt_next      = cnt_reg + 1'b1;
                                newest_s_next = c_s;
                                newest_e_next = c_e;
                                cutoff_next   = $signed({1'b0, c_e})
                                                - $signed({1'b0, window_length});
                                state_next    = EX_EVICT;
                            end
                        end
                        FUNC_SNAPSHOT:
                        begin
                            if (cnt_reg == '0)
                            begin
                                st_next = ST_NONE;
                                wend_next = '0;
                                req_next = '0;
                                act_next = '0;
                                state_next = EX_RESULT;
                            end
                            else
                            begin
                                wend_next = (c_q < newest_e_reg) ? c_q : newest_e_reg;
                                state_next = EX_FIND;
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            cnt_next  = '0;
                            head_next = '0;
                            state_next = EX_RESULT;
                        end
                        FUNC_TRIM:
                        begin
                            state_next = (cnt_reg == '0) ? EX_RESULT : EX_EVICT;
                        end
                        default: state_next = EX_RESULT;
                    endcase
                end
            end
            EX_EVICT:
            begin
                // read head entry, drop while its end is at or before cutoff
                if (rd_wait_reg)
                begin
                    rd_wait_next = 1'b0;
                end
                else if (cnt_reg != '0 && rd_e_x <= cutoff_reg)
                begin
                    head_next    = ring(head_reg, CW'(1));
                    cnt_next     = cnt_reg - 1'b1;
                    rd_wait_next = 1'b1;
                end
                else
                begin
                    if (cnt_reg != '0)
                    begin
                        oldest_s_next = rd_s;
                    end
                    state_next = EX_RESULT;
                end
            end
            EX_FIND:
            begin
                req_next = $signed({1'b0, wend_reg}) - $signed({1'b0, window_length});
                if (rd_wait_reg)
                begin
                    rd_wait_next = 1'b0;
                end
                else if ((rd_s_x <= req_reg && rd_e_x > req_reg) || rd_s_x > req_reg)
                begin
                    act_next     = rd_s;
                    state_next   = EX_EMIT;
                    rd_wait_next = 1'b0;
                end
                else if (idx_reg + 1'b1 == cnt_reg)
                begin
                    // nothing covers: fall back to the oldest entry
                    idx_next     = '0;
                    act_next     = oldest_s_reg;
                    rd_wait_next = 1'b1;
                    state_next   = EX_EMIT;
                end
                else
                begin
                    idx_next     = idx_reg + 1'b1;
                    rd_wait_next = 1'b1;
                end
            end
            EX_EMIT:
            begin
                // rd_* holds entry idx_reg and rd_nx_s the next start when rd_wait_reg is low
                if (rd_wait_reg)
                begin
                    rd_wait_next = 1'b0;
                end
                else if (!ov_next)
                begin
                    if (idx_reg < cnt_reg && rd_s < wend_reg)
                    begin
                        ov_next       = 1'b1;
                        o_status_next = ST_OK;
                        o_iv_next     = 1'b1;
                        o_h_next      = rd_h;
                        o_s_next      = rd_s;
                        o_e_next      = rd_e;
                        o_wend_next   = wend_reg;
                        o_req_next    = req_reg;
                        o_act_next    = act_reg;
                        o_cnt_next    = COUNT_W'(cnt_reg);
                        o_old_next    = oldest_s_reg;
                        o_new_next    = newest_e_reg;
                        o_last_next   = nx_last;
                        emitted_next  = 1'b1;
                        idx_next      = idx_reg + 1'b1;
                        rd_wait_next  = 1'b1;
                        if (nx_last)
                        begin
                            state_next = EX_IDLE;
                        end
                    end
                    else if (emitted_reg)
                    begin
                        // all selected entries sent
                        state_next = EX_IDLE;
                    end
                    else
                    begin
                        st_next    = ST_NONE;
                        state_next = EX_RESULT;
                    end
                end
            end
            EX_RESULT:
            begin
                if (!ov_next)
                begin
                    ov_next       = 1'b1;
                    o_status_next = st_reg;
                    o_iv_next     = 1'b0;
                    o_h_next      = '0;
                    o_s_next      = '0;
                    o_e_next      = '0;
                    o_last_next   = 1'b1;
                    o_wend_next   = (func_reg == FUNC_SNAPSHOT) ? wend_reg : '0;
                    o_req_next    = (func_reg == FUNC_SNAPSHOT) ? req_reg : '0;
                    o_act_next    = (func_reg == FUNC_SNAPSHOT) ? act_reg : '0;
                    o_cnt_next    = COUNT_W'(cnt_reg);
                    o_old_next    = (cnt_reg != '0) ? oldest_s_reg : '0;
                    o_new_next    = (cnt_reg != '0) ? newest_e_reg : '0;
                    state_next    = EX_IDLE;
                end
            end
            default: state_next = EX_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EX_IDLE;
            head_reg  <= '0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        newest_s_reg <= newest_s_next;
        newest_e_reg <= newest_e_next;
        oldest_s_reg <= oldest_s_next;
        func_reg     <= func_next;
        wend_reg     <= wend_next;
        req_reg      <= req_next;
        cutoff_reg   <= cutoff_next;
        act_reg      <= act_next;
        idx_reg      <= idx_next;
        rd_wait_reg  <= rd_wait_next;
        emitted_reg  <= emitted_next;
        st_reg       <= st_next;
        o_status_reg <= o_status_next;
        o_iv_reg     <= o_iv_next;
        o_last_reg   <= o_last_next;
        o_h_reg      <= o_h_next;
        o_s_reg      <= o_s_next;
        o_e_reg      <= o_e_next;
        o_wend_reg   <= o_wend_next;
        o_req_reg    <= o_req_next;
        o_act_reg    <= o_act_next;
        o_cnt_reg    <= o_cnt_next;
        o_old_reg    <= o_old_next;
        o_new_reg    <= o_new_next;
    end

endmodule

>>> hw/rtl/time_window_segment_buffer.sv
// ----------------------------------------------------------------------------
// time_window_segment_buffer
// Time-ordered ring of segment descriptors with sliding-window eviction.
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// s_axis   in         s_axis_tvalid/tready   tdata: func, seg_start, seg_end,
//                                              seg_handle, query_time
// m_axis   out        m_axis_tvalid/tready   tdata + tlast
// cfg      in         cfg_valid/cfg_ready    window_length
//
// Sequencer steps: clear, a rejected append and a trim of an empty ring go
// straight to the result; an accepted append or a trim first evicts expired
// head entries one by one; a snapshot skips entries until one covers or
// follows the requested start, then sends the selected ones or reports none.
// Each RAM read has a wait state. Reset clears the ring (count and head),
// the queue and the output valid flag and sets the window to 30000000. The
// input queue holds two items; a stalled output holds the sequencer.
// ----------------------------------------------------------------------------
module time_window_segment_buffer #(
    parameter int unsigned DEPTH       = 32,
    parameter int unsigned TIME_BITS   = 48,
    parameter int unsigned HANDLE_BITS = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // func, seg_start, seg_end, seg_handle, query_time (low to high)
    input  logic [((2 + 3*TIME_BITS + HANDLE_BITS + 7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // status, item_valid, out_handle, out_start, out_end, window_end,
    // requested_start, actual_start, entry_count, oldest_start, newest_end
    output logic [((3 + 1 + HANDLE_BITS + 7*TIME_BITS + 1 + 6 + 7)/8)*8-1:0]
                 m_axis_tdata,
    output logic m_axis_tlast,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [TIME_BITS-1:0] cfg_data
);
    import twsb_pkg::*;

    localparam int unsigned CMD_W  = 2 + 3*TIME_BITS + HANDLE_BITS;
    localparam int unsigned IN_W   = ((CMD_W + 7)/8)*8;
    localparam int unsigned PRE_W  = 3 + 1 + HANDLE_BITS + 5*TIME_BITS + 1;
    localparam int unsigned RES_W  = PRE_W + 1 + COUNT_W + 2*TIME_BITS;
    localparam int unsigned OUT_W  = ((RES_W - 1 + 7)/8)*8;

    logic [TIME_BITS-1:0] window_reg;
    logic                 q_valid, q_ready;
    logic [CMD_W-1:0]     q_cmd;
    logic [RES_W-1:0]     res;

    assign cfg_ready = 1'b1;

    // hold window length; ignore zero writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= TIME_BITS'(30000000);
        end
        else if (cfg_valid && cfg_data != '0)
        begin
            window_reg <= cfg_data;
        end
    end

    twsb_front #(.CMD_W(CMD_W)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_cmd(s_axis_tdata[CMD_W-1:0]),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd));

    twsb_back #(
        .DEPTH(DEPTH), .TIME_BITS(TIME_BITS), .HANDLE_BITS(HANDLE_BITS),
        .CMD_W(CMD_W), .RES_W(RES_W)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .window_length(window_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_data(res));

    // split the last flag out of the result word
    assign m_axis_tlast = res[PRE_W];
    assign m_axis_tdata = OUT_W'({res[RES_W-1:PRE_W+1], res[PRE_W-1:0]});

endmodule
